// File: design/npse_pkg.sv
`timescale 1ns / 1ps
package npse_pkg;

  // Field and register widths.
  localparam int SAMPLE_W     = 32;
  localparam int COEF_W       = 32;
  localparam int CFG_SIZE_W   = 11;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int IDX_OUT_W    = 10;
  localparam int ROW_W        = 10;

  // Grid limits.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS     = 1024;
  localparam int MIN_SIZE     = 3;

  // Datapath widths: combined operands, products and sums.
  localparam int WIDE_OP_W    = SAMPLE_W + 2;
  localparam int PROD_W       = WIDE_OP_W + COEF_W;
  localparam int PSUM_W       = PROD_W + 1;
  localparam int TOTAL_W      = PSUM_W + 2;
  localparam int FRAC_SHIFT   = 28;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS     = 2'd0,
    CFG_GRID_COLS     = 2'd1,
    CFG_RHO_WEIGHT    = 2'd2,
    CFG_SOURCE_ENABLE = 2'd3
  } cfg_idx_e;

  // Position and end-of-grid marker that travel with each result.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
  } pt_tag_t;

  // Operand set for one interior point, all fields two's complement.
  typedef struct packed {
    logic [WIDE_OP_W-1:0] diag_sum;     // NW - NE - SW + SE
    logic [COEF_W-1:0]    coef_diag;
    logic [SAMPLE_W-1:0]  val_north;
    logic [COEF_W-1:0]    coef_north;
    logic [SAMPLE_W-1:0]  val_west;
    logic [COEF_W-1:0]    coef_west;
    logic [SAMPLE_W-1:0]  val_centre;
    logic [WIDE_OP_W-1:0] coef_centre;  // one - Z - W
    logic [SAMPLE_W-1:0]  val_east;
    logic [COEF_W-1:0]    coef_east;
    logic [SAMPLE_W-1:0]  val_south;
    logic [COEF_W-1:0]    coef_south;
    logic [COEF_W-1:0]    src_weight;   // zero when the source term is off
    logic [SAMPLE_W-1:0]  src_value;
  } calc_op_t;

endpackage

// File: design/npse_calc.sv
`timescale 1ns / 1ps
module npse_calc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_valid_i,
  input  npse_pkg::calc_op_t               op_i,
  input  npse_pkg::pt_tag_t                tag_i,
  output logic                             op_ready_o,
  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic [npse_pkg::SAMPLE_W-1:0]    res_value_o,
  output npse_pkg::pt_tag_t                res_tag_o
);
  import npse_pkg::*;

  localparam logic [PSUM_W-1:0] RND_BIAS = PSUM_W'(1) << (FRAC_SHIFT - 1);
  localparam int SH_W = TOTAL_W - FRAC_SHIFT;

  // Stage valids and load enables; a stage loads when empty or when it drains.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !res_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign op_ready_o = en1;

  // Stage 1: operand register.
  calc_op_t op_q;
  pt_tag_t  tag1_q, tag2_q, tag3_q, tag4_q;

  always_ff @(posedge clk_i) begin
    if (en1 && op_valid_i) begin
      op_q   <= op_i;
      tag1_q <= tag_i;
    end
  end

  // Stage 2: seven independent products.
  logic signed [WIDE_OP_W-1:0] diag_s, ccen_s;
  logic signed [SAMPLE_W-1:0]  vn_s, vw_s, vc_s, ve_s, vs_s, src_s;
  logic signed [COEF_W-1:0]    cd_s, cn_s, cw_s, ce_s, cs_s, rho_s;
  logic signed [PROD_W-1:0]    p_diag, p_north, p_west, p_centre, p_east, p_south, p_src;

  assign diag_s = $signed(op_q.diag_sum);
  assign ccen_s = $signed(op_q.coef_centre);
  assign vn_s   = $signed(op_q.val_north);
  assign vw_s   = $signed(op_q.val_west);
  assign vc_s   = $signed(op_q.val_centre);
  assign ve_s   = $signed(op_q.val_east);
  assign vs_s   = $signed(op_q.val_south);
  assign src_s  = $signed(op_q.src_value);
  assign cd_s   = $signed(op_q.coef_diag);
  assign cn_s   = $signed(op_q.coef_north);
  assign cw_s   = $signed(op_q.coef_west);
  assign ce_s   = $signed(op_q.coef_east);
  assign cs_s   = $signed(op_q.coef_south);
  assign rho_s  = $signed(op_q.src_weight);

  assign p_diag   = diag_s * cd_s;
  assign p_north  = vn_s * cn_s;
  assign p_west   = vw_s * cw_s;
  assign p_centre = ccen_s * vc_s;
  assign p_east   = ve_s * ce_s;
  assign p_south  = vs_s * cs_s;
  assign p_src    = rho_s * src_s;

  logic [PROD_W-1:0] pd_q, pn_q, pw_q, pc_q, pe_q, ps_q, pr_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pd_q   <= p_diag;
      pn_q   <= p_north;
      pw_q   <= p_west;
      pc_q   <= p_centre;
      pe_q   <= p_east;
      ps_q   <= p_south;
      pr_q   <= p_src;
      tag2_q <= tag1_q;
    end
  end

  // Stage 3: pairwise sums, with the rounding bias folded into the source pair.
  logic [PSUM_W-1:0] sa_d, sb_d, sc_d, sd_d;
  logic [PSUM_W-1:0] sa_q, sb_q, sc_q, sd_q;

  assign sa_d = {pd_q[PROD_W-1], pd_q} + {pn_q[PROD_W-1], pn_q};
  assign sb_d = {pw_q[PROD_W-1], pw_q} + {pc_q[PROD_W-1], pc_q};
  assign sc_d = {pe_q[PROD_W-1], pe_q} + {ps_q[PROD_W-1], ps_q};
  assign sd_d = {pr_q[PROD_W-1], pr_q} + RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      sa_q   <= sa_d;
      sb_q   <= sb_d;
      sc_q   <= sc_d;
      sd_q   <= sd_d;
      tag3_q <= tag2_q;
    end
  end

  // Stage 4: final sum, floor shift to Q16.16 and saturation.
  logic [TOTAL_W-1:0]  total;
  logic [SH_W-1:0]     shifted;
  logic                fits;
  logic [SAMPLE_W-1:0] sat_d, value_q;

  assign total = {{2{sa_q[PSUM_W-1]}}, sa_q} + {{2{sb_q[PSUM_W-1]}}, sb_q}
               + {{2{sc_q[PSUM_W-1]}}, sc_q} + {{2{sd_q[PSUM_W-1]}}, sd_q};
  assign shifted = total[TOTAL_W-1:FRAC_SHIFT];
  assign fits = (&shifted[SH_W-1:SAMPLE_W-1]) || !(|shifted[SH_W-1:SAMPLE_W-1]);

  always_comb begin
    if (fits) begin
      sat_d = shifted[SAMPLE_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat_d = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      value_q <= sat_d;
      tag4_q  <= tag3_q;
    end
  end

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= op_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign res_valid_o = v4_q;
  assign res_value_o = value_q;
  assign res_tag_o   = tag4_q;

`ifndef NO_ASSERTIONS
  // An offered operand set that is taken must show up in the first stage.
  a_load_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i && op_ready_o |=> v1_q)
    else $error("operand beat lost at the first stage");

  // Refusing operands only happens when every stage is full and the output is stalled.
  a_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_ready_o |-> v1_q && v2_q && v3_q && v4_q && res_stall_i)
    else $error("operands refused while the pipeline has a bubble");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !res_stall_i && !v3_q |=> !v4_q)
    else $error("result repeated after it was taken");
`endif

endmodule

// File: design/nine_point_stencil_euler_step.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Beat contents
// input     in         in_valid_i / in_stall_o   sample, seven coefficients, source value
// result    out        out_valid_o / out_stall_i new_value, out_row, out_col, last_point
// config    in         cfg_we_i                  cfg_idx_i selects register, cfg_wdata_i
//
// One input beat is taken per cycle while in_stall_o is low; the beat that completes
// a point goes through the operand, product, partial-sum and output registers.
// The line stores are single-port-per-side arrays read one column ahead, so
// back-to-back beats never wait on them. Reset clears the counters, window and
// pipeline valids; line store contents stay undefined. in_stall_o rises only when
// all four pipeline stages are full and out_stall_i holds the output.
module nine_point_stencil_euler_step #(
  parameter int MAX_COLS = npse_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [npse_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_diag_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_north_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_west_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_south_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_east_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_z_i,
  input  logic [npse_pkg::COEF_W-1:0]        coef_w_i,
  input  logic [npse_pkg::SAMPLE_W-1:0]      source_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [npse_pkg::SAMPLE_W-1:0]      new_value_o,
  output logic [npse_pkg::IDX_OUT_W-1:0]     out_row_o,
  output logic [npse_pkg::IDX_OUT_W-1:0]     out_col_o,
  output logic                               last_point_o,
  input  logic                               cfg_we_i,
  input  logic [npse_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [npse_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import npse_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int SZ_W  = (COL_W + 1 > CFG_SIZE_W) ? COL_W + 1 : CFG_SIZE_W;
  localparam int OC_W  = (COL_W > IDX_OUT_W) ? COL_W : IDX_OUT_W;
  localparam logic [WIDE_OP_W-1:0] ONE_Q28 = WIDE_OP_W'(1) << FRAC_SHIFT;

  // Configuration registers.
  logic [CFG_SIZE_W-1:0] grid_rows_q, grid_cols_q;
  logic [COEF_W-1:0]     rho_weight_q;
  logic                  source_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q     <= CFG_SIZE_W'(MIN_SIZE);
      grid_cols_q     <= CFG_SIZE_W'(MIN_SIZE);
      rho_weight_q    <= '0;
      source_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_ROWS:     grid_rows_q     <= cfg_wdata_i[CFG_SIZE_W-1:0];
        CFG_GRID_COLS:     grid_cols_q     <= cfg_wdata_i[CFG_SIZE_W-1:0];
        CFG_RHO_WEIGHT:    rho_weight_q    <= cfg_wdata_i[COEF_W-1:0];
        CFG_SOURCE_ENABLE: source_enable_q <= cfg_wdata_i[0];
        default:           rho_weight_q    <= rho_weight_q;
      endcase
    end
  end

  // Grid size, clamped to the supported range.
  logic [SZ_W-1:0]       cols_raw, cols_lim;
  logic [CFG_SIZE_W-1:0] rows_lim;

  assign cols_raw = SZ_W'(grid_cols_q);

  always_comb begin
    if (cols_raw < SZ_W'(MIN_SIZE)) begin
      cols_lim = SZ_W'(MIN_SIZE);
    end else if (cols_raw > SZ_W'(MAX_COLS)) begin
      cols_lim = SZ_W'(MAX_COLS);
    end else begin
      cols_lim = cols_raw;
    end
    if (grid_rows_q < CFG_SIZE_W'(MIN_SIZE)) begin
      rows_lim = CFG_SIZE_W'(MIN_SIZE);
    end else if (grid_rows_q > CFG_SIZE_W'(MAX_ROWS)) begin
      rows_lim = CFG_SIZE_W'(MAX_ROWS);
    end else begin
      rows_lim = grid_rows_q;
    end
  end

  // Raster position counters.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             col_end, row_end, emit, in_accept, calc_ready;

  assign col_end   = SZ_W'(col_q) >= (cols_lim - SZ_W'(1));
  assign row_end   = CFG_SIZE_W'(row_q) >= (rows_lim - CFG_SIZE_W'(1));
  assign emit      = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
  assign in_accept = in_valid_i && calc_ready;
  assign in_stall_o = !calc_ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores. The read address runs one beat ahead so the registered read
  // data belongs to the column of the next beat; the write goes to the current
  // column, which always differs from the address being read.
  logic [SAMPLE_W-1:0] upper_mem [MAX_COLS];
  logic [SAMPLE_W-1:0] lower_mem [MAX_COLS];
  logic [SAMPLE_W-1:0] up_rd_q, lo_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      upper_mem[col_q] <= lo_rd_q;
      lower_mem[col_q] <= sample_i;
    end
    up_rd_q <= upper_mem[col_d];
    lo_rd_q <= lower_mem[col_d];
  end

  // 3x3 window: left and middle columns held here, right column from the
  // line stores and the incoming sample.
  logic [SAMPLE_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (in_accept) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd_q;
      win_q[4] <= lo_rd_q;
      win_q[5] <= sample_i;
    end
  end

  // Operands for the point completed by this beat.
  calc_op_t op;
  pt_tag_t  tag;
  logic [OC_W-1:0] col_m1;

  assign col_m1 = OC_W'(col_q) - OC_W'(1);

  always_comb begin
    op.diag_sum    = {{2{win_q[0][SAMPLE_W-1]}}, win_q[0]}
                   - {{2{up_rd_q[SAMPLE_W-1]}}, up_rd_q}
                   - {{2{win_q[2][SAMPLE_W-1]}}, win_q[2]}
                   + {{2{sample_i[SAMPLE_W-1]}}, sample_i};
    op.coef_diag   = coef_diag_i;
    op.val_north   = win_q[3];
    op.coef_north  = coef_north_i;
    op.val_west    = win_q[1];
    op.coef_west   = coef_west_i;
    op.val_centre  = win_q[4];
    op.coef_centre = ONE_Q28
                   - {{2{coef_z_i[COEF_W-1]}}, coef_z_i}
                   - {{2{coef_w_i[COEF_W-1]}}, coef_w_i};
    op.val_east    = lo_rd_q;
    op.coef_east   = coef_east_i;
    op.val_south   = win_q[5];
    op.coef_south  = coef_south_i;
    op.src_weight  = source_enable_q ? rho_weight_q : '0;
    op.src_value   = source_value_i;
    tag.row        = row_q - ROW_W'(1);
    tag.col        = col_m1[IDX_OUT_W-1:0];
    tag.last       = row_end && col_end;
  end

  // Arithmetic pipeline with output register.
  pt_tag_t res_tag;

  npse_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (in_valid_i && emit),
    .op_i        (op),
    .tag_i       (tag),
    .op_ready_o  (calc_ready),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_value_o (new_value_o),
    .res_tag_o   (res_tag)
  );

  assign out_row_o    = res_tag.row;
  assign out_col_o    = res_tag.col;
  assign last_point_o = res_tag.last;

`ifndef NO_ASSERTIONS
  // The column counter never leaves the line store depth.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (COL_W + 1)'(col_q) < (COL_W + 1)'(MAX_COLS))
    else $error("column counter beyond line store depth");

  // The beat at the end of a row sends the column counter back to zero.
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && col_end |=> col_q == '0)
    else $error("column counter did not wrap at row end");

  // The input is held back only while a finished result waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // The beat that ends the grid sends the row counter back to zero.
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && col_end && row_end |=> row_q == '0)
    else $error("row counter did not return to zero at grid end");
`endif

endmodule
